// ===== hw/rtl/lprr_pkg.sv =====
// ----------------------------------------------------------------------------
// lprr_pkg
// Shared constants, codes and controller/datapath interface types for the
// length-prefixed record ring.
// ----------------------------------------------------------------------------
package lprr_pkg;

   localparam int RING_WORDS       = 1024;
   localparam int MAX_RECORD_WORDS = 64;
   localparam int RING_AW          = $clog2(RING_WORDS);
   localparam int WORD_W           = 64;
   localparam int PBYTES_W         = 9;
   localparam int CNT_W            = PBYTES_W - 3 + 1;
   localparam int RB_W             = 10;
   localparam int STATUS_W         = 2;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EXTRA    = 2'd3;

   typedef struct packed {
      logic capture;
      logic push_open;
      logic push_data;
      logic push_zero;
      logic pop_empty;
      logic pop_head;
      logic pop_size;
      logic pop_emit;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic rejected;
      logic last;
      logic rem_zero;
      logic rem_one;
      logic used_zero;
      logic out_free;
      logic pop_last;
   } stat_type;

endpackage

// ===== hw/rtl/lprr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lprr_ctrl
// Sequencer for push and pop transactions; drives the datapath by commands.
// ----------------------------------------------------------------------------
module lprr_ctrl
   import lprr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_type,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PCHK  = 3'd1;
   localparam logic [2:0] S_PDATA = 3'd2;
   localparam logic [2:0] S_PZERO = 3'd3;
   localparam logic [2:0] S_QCHK  = 3'd4;
   localparam logic [2:0] S_QHDR  = 3'd5;
   localparam logic [2:0] S_QOUT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_type == REQ_POP) begin
                  state_in = S_QCHK;
               end else if (stat.active) begin
                  state_in = S_PDATA;
               end else begin
                  state_in = S_PCHK;
               end
            end
         end
         S_PCHK: begin
            cmd.push_open = 1'b1;
            state_in      = S_PDATA;
         end
         S_PDATA: begin
            if (stat.out_free) begin
               cmd.push_data = 1'b1;
               if (!stat.rejected && stat.last && !stat.rem_zero && !stat.rem_one) begin
                  state_in = S_PZERO;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PZERO: begin
            cmd.push_zero = 1'b1;
            if (stat.rem_one) begin
               state_in = S_IDLE;
            end
         end
         S_QCHK: begin
            if (stat.used_zero) begin
               if (stat.out_free) begin
                  cmd.pop_empty = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.pop_head = 1'b1;
               state_in     = S_QHDR;
            end
         end
         S_QHDR: begin
            cmd.pop_size = 1'b1;
            state_in     = S_QOUT;
         end
         S_QOUT: begin
            if (stat.out_free) begin
               cmd.pop_emit = 1'b1;
               if (stat.pop_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/lprr_dp.sv =====
// ----------------------------------------------------------------------------
// lprr_dp
// Ring memory, ring indices, message tracking and the result register.
// ----------------------------------------------------------------------------
module lprr_dp
   import lprr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [PBYTES_W-1:0] req_payload_byte_count,
   input  logic [WORD_W-1:0]   req_push_word,
   input  logic                req_push_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [WORD_W-1:0]   rsp_pop_word,
   output logic [RB_W-1:0]     rsp_record_bytes,
   output logic                rsp_run_last
);

   logic [WORD_W-1:0] ring_mem [RING_WORDS];

   logic [RING_AW-1:0]  tail_ff, tail_in, head_ff, head_in, widx_ff, widx_in;
   logic [RING_AW-1:0]  pop_ptr_ff, pop_ptr_in;
   logic [CNT_W-1:0]    rem_ff, rem_in, words_ff, words_in, k_ff, k_in;
   logic                active_ff, active_in, rejected_ff, rejected_in;
   logic [PBYTES_W-1:0] pbytes_ff;
   logic [WORD_W-1:0]   word_ff;
   logic                last_ff;
   logic [WORD_W-1:0]   rd_data_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0]   pop_word_ff, pop_word_in;
   logic [RB_W-1:0]     rb_ff, rb_in;
   logic                run_last_ff, run_last_in;
   logic                out_load;

   logic                wr_en;
   logic [RING_AW-1:0]  wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic                rd_en;
   logic [RING_AW-1:0]  rd_addr;

   logic [RING_AW:0]    used_wide;
   logic [RING_AW-1:0]  used;
   logic [CNT_W-1:0]    recw;
   logic                reject;
   logic [CNT_W-1:0]    hdr_words;
   logic [CNT_W-1:0]    clamp_words;
   logic                out_free;
   logic                pop_last;

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
      logic [RING_AW-1:0] r;
      if (i == RING_AW'(RING_WORDS - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      used_wide = {1'b0, tail_ff} - {1'b0, head_ff};
      if (tail_ff < head_ff) begin
         used_wide = used_wide + (RING_AW+1)'(RING_WORDS);
      end
      used = used_wide[RING_AW-1:0];
   end

   assign recw   = CNT_W'(((10'(pbytes_ff) + 10'd7) >> 3) + 10'd1);
   assign reject = (recw > CNT_W'(MAX_RECORD_WORDS)) ||
                   (((RING_AW+1)'(recw) + (RING_AW+1)'(used)) >=
                    (RING_AW+1)'(RING_WORDS));

   always_comb begin
      if (rd_data_ff[WORD_W-1:3] > (WORD_W-3)'(MAX_RECORD_WORDS)) begin
         hdr_words = CNT_W'(MAX_RECORD_WORDS);
      end else if (rd_data_ff[WORD_W-1:3] == '0) begin
         hdr_words = CNT_W'(1);
      end else begin
         hdr_words = rd_data_ff[CNT_W+2:3];
      end
      if (RING_AW'(hdr_words) > used) begin
         clamp_words = used[CNT_W-1:0];
      end else begin
         clamp_words = hdr_words;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop_last = (k_ff == words_ff - 1'b1);

   always_comb begin
      stat.active    = active_ff;
      stat.rejected  = rejected_ff;
      stat.last      = last_ff;
      stat.rem_zero  = (rem_ff == '0);
      stat.rem_one   = (rem_ff == CNT_W'(1));
      stat.used_zero = (used == '0);
      stat.out_free  = out_free;
      stat.pop_last  = pop_last;
   end

   always_comb begin
      tail_in     = tail_ff;
      head_in     = head_ff;
      widx_in     = widx_ff;
      rem_in      = rem_ff;
      active_in   = active_ff;
      rejected_in = rejected_ff;
      pop_ptr_in  = pop_ptr_ff;
      words_in    = words_ff;
      k_in        = k_ff;
      wr_en       = 1'b0;
      wr_addr     = widx_ff;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      out_load    = 1'b0;
      status_in   = ST_OK;
      pop_word_in = '0;
      rb_in       = '0;
      run_last_in = 1'b1;

      if (cmd.push_open) begin
         active_in = 1'b1;
         if (reject) begin
            rejected_in = 1'b1;
         end else begin
            rejected_in = 1'b0;
            wr_en       = 1'b1;
            wr_addr     = tail_ff;
            wr_data     = WORD_W'({recw, 3'b000});
            widx_in     = ring_next(tail_ff);
            rem_in      = recw - 1'b1;
         end
      end

      if (cmd.push_data) begin
         out_load = 1'b1;
         if (rejected_ff) begin
            status_in = ST_REJECTED;
            if (last_ff) begin
               active_in   = 1'b0;
               rejected_in = 1'b0;
            end
         end else begin
            if (rem_ff != '0) begin
               wr_en     = 1'b1;
               wr_addr   = widx_ff;
               wr_data   = word_ff;
               widx_in   = ring_next(widx_ff);
               rem_in    = rem_ff - 1'b1;
               status_in = ST_OK;
            end else begin
               status_in = ST_EXTRA;
            end
            if (last_ff && (rem_ff == '0 || rem_ff == CNT_W'(1))) begin
               tail_in   = widx_in;
               active_in = 1'b0;
            end
         end
      end

      if (cmd.push_zero) begin
         wr_en   = 1'b1;
         wr_addr = widx_ff;
         wr_data = '0;
         widx_in = ring_next(widx_ff);
         rem_in  = rem_ff - 1'b1;
         if (rem_ff == CNT_W'(1)) begin
            tail_in   = widx_in;
            active_in = 1'b0;
         end
      end

      if (cmd.pop_empty) begin
         out_load  = 1'b1;
         status_in = ST_EMPTY;
      end

      if (cmd.pop_head) begin
         rd_en      = 1'b1;
         rd_addr    = head_ff;
         pop_ptr_in = head_ff;
      end

      if (cmd.pop_size) begin
         words_in = clamp_words;
         k_in     = '0;
      end

      if (cmd.pop_emit) begin
         out_load    = 1'b1;
         status_in   = ST_OK;
         pop_word_in = rd_data_ff;
         rb_in       = {words_ff, 3'b000};
         run_last_in = pop_last;
         if (pop_last) begin
            head_in = ring_next(pop_ptr_ff);
         end else begin
            pop_ptr_in = ring_next(pop_ptr_ff);
            rd_en      = 1'b1;
            rd_addr    = ring_next(pop_ptr_ff);
            k_in       = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff      <= '0;
         head_ff      <= '0;
         widx_ff      <= '0;
         rem_ff       <= '0;
         active_ff    <= 1'b0;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tail_ff     <= tail_in;
         head_ff     <= head_in;
         widx_ff     <= widx_in;
         rem_ff      <= rem_in;
         active_ff   <= active_in;
         rejected_ff <= rejected_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pop_ptr_ff <= pop_ptr_in;
      words_ff   <= words_in;
      k_ff       <= k_in;
      if (cmd.capture) begin
         pbytes_ff <= req_payload_byte_count;
         word_ff   <= req_push_word;
         last_ff   <= req_push_last;
      end
      if (out_load) begin
         status_ff   <= status_in;
         pop_word_ff <= pop_word_in;
         rb_ff       <= rb_in;
         run_last_ff <= run_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_pop_word     = pop_word_ff;
   assign rsp_record_bytes = rb_ff;
   assign rsp_run_last     = run_last_ff;

endmodule

// ===== hw/rtl/length_prefixed_record_ring.sv =====
// Push: the result follows the accept; on a message's first word the header is written first;
//   early last writes a zero word per missing payload word before the next accept.
// Pop: the header is read, then one word per cycle while the result channel is free; empty pop gives one result.
// One transaction in work at a time: no new request is accepted until the last one is done.
// Synchronous reset empties the ring; memory contents are not cleared.
// ----------------------------------------------------------------------------
// length_prefixed_record_ring
// Ring buffer of 64-bit words holding length-prefixed variable-length records.
// ----------------------------------------------------------------------------
module length_prefixed_record_ring
   import lprr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [PBYTES_W-1:0] req_payload_byte_count,
   input  logic [WORD_W-1:0]   req_push_word,
   input  logic                req_push_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [WORD_W-1:0]   rsp_pop_word,
   output logic [RB_W-1:0]     rsp_record_bytes,
   output logic                rsp_run_last
);

   cmd_type  cmd;
   stat_type stat;

   lprr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   lprr_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_payload_byte_count (req_payload_byte_count),
      .req_push_word          (req_push_word),
      .req_push_last          (req_push_last),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status             (rsp_status),
      .rsp_pop_word           (rsp_pop_word),
      .rsp_record_bytes       (rsp_record_bytes),
      .rsp_run_last           (rsp_run_last)
   );

endmodule

// ===== hw/rtl/lprr_checker.sv =====
// ----------------------------------------------------------------------------
// lprr_checker
// Port-level checks on the record ring result channel.
// ----------------------------------------------------------------------------
module lprr_checker
   import lprr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [WORD_W-1:0]   rsp_pop_word,
   input logic [RB_W-1:0]     rsp_record_bytes,
   input logic                rsp_run_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pop_word) &&
                                  $stable(rsp_status))
      else $error("result changed while stalled");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_run_last)
      else $error("non-ok transaction result not final");

   a_push_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_REJECTED || rsp_status == ST_EXTRA ||
                    rsp_status == ST_EMPTY)
      |-> rsp_pop_word == '0 && rsp_record_bytes == '0)
      else $error("push or empty result carries data");

   a_rec_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_bytes != '0
      |-> rsp_record_bytes[2:0] == 3'b000 &&
          rsp_record_bytes <= RB_W'(MAX_RECORD_WORDS * 8))
      else $error("bad record length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind length_prefixed_record_ring lprr_checker u_lprr_checker (.*);
